/* design/booth_radix4_multiplier_defines.svh */
// ----------------------------------------------------------------------------
// booth_radix4_multiplier_defines: assertion macros
// Shared concurrent assertion forms for the multiplier checker. Both sample on
// clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOOTH_RADIX4_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX4_MULTIPLIER_DEFINES_SVH

// same-cycle implication
`define BRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brm assertion failed");

// next-cycle implication
`define BRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brm assertion failed");

`endif

/* design/brm_pkg.sv */
// ----------------------------------------------------------------------------
// brm_pkg
// Widths, counts and types shared by the radix-4 Booth multiplier.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int IN_W         = 32;
  localparam int OUT_W        = 64;
  localparam int PROD_W       = 2 * OPERAND_BITS;
  // one partial product per booth window
  localparam int NUM_PP       = (OPERAND_BITS + 1) / 2;
  // partial products plus the negation row, padded to a power of two
  localparam int NUM_LEAVES   = 1 << $clog2(NUM_PP + 1);

  typedef logic [PROD_W-1:0]                  prod_t;
  typedef logic [NUM_LEAVES-1:0][PROD_W-1:0]  pp_array_t;

endpackage

/* design/brm_booth_encoder.sv */
// ----------------------------------------------------------------------------
// brm_booth_encoder
// Recodes the multiplier in overlapping 3-bit windows and forms the shifted,
// sign-extended partial products plus one row of negation correction bits.
// ----------------------------------------------------------------------------
module brm_booth_encoder
  import brm_pkg::*;
(
  input  logic [OPERAND_BITS-1:0] mcand_i,
  input  logic [OPERAND_BITS-1:0] mplier_i,
  output pp_array_t               pp_o
);

  prod_t             m_ext;
  logic [NUM_PP-1:0] neg_w;
  prod_t             neg_row;

  assign m_ext = {{(PROD_W - OPERAND_BITS){mcand_i[OPERAND_BITS-1]}}, mcand_i};

  for (genvar k = 0; k < NUM_PP; k++) begin : g_win
    logic  b2, b1, b0;
    logic  zero, two, neg;
    prod_t sel;
    prod_t row;

    if (k == 0) begin : g_lsb
      assign b0 = 1'b0;
    end else begin : g_mid
      assign b0 = mplier_i[2*k-1];
    end

    assign b1 = mplier_i[2*k];

    // odd width: top window repeats the sign bit
    if (2*k + 1 < OPERAND_BITS) begin : g_hi
      assign b2 = mplier_i[2*k+1];
    end else begin : g_sign
      assign b2 = mplier_i[OPERAND_BITS-1];
    end

    assign zero = (b2 == b1) && (b1 == b0);
    assign two  = (b2 != b1) && (b1 == b0);
    assign neg  = b2 && !zero;
    assign sel  = two ? (m_ext << 1) : m_ext;
    // ones complement here, the +1 goes in the correction row
    assign row  = zero ? '0 : (neg ? ~sel : sel);

    assign neg_w[k] = neg;
    assign pp_o[k]  = row << (2*k);
  end

  always_comb begin
    neg_row = '0;
    for (int k = 0; k < NUM_PP; k++) begin
      neg_row[2*k] = neg_w[k];
    end
  end

  assign pp_o[NUM_PP] = neg_row;

  for (genvar j = NUM_PP + 1; j < NUM_LEAVES; j++) begin : g_pad
    assign pp_o[j] = '0;
  end

endmodule

/* design/brm_csa_tree.sv */
// ----------------------------------------------------------------------------
// brm_csa_tree
// Carry-save reduction of the partial product rows to one sum and one carry
// vector, built as a binary tree of 4:2 compressors (two 3:2 stages each).
// ----------------------------------------------------------------------------
module brm_csa_tree
  import brm_pkg::*;
(
  input  pp_array_t leaves_i,
  output prod_t     sum_o,
  output prod_t     carry_o
);

  localparam int NUM_NODES = 2 * NUM_LEAVES - 1;

  // heap order: node n has children 2n+1 and 2n+2, leaves at the end
  prod_t node_s [NUM_NODES];
  prod_t node_c [NUM_NODES];

  for (genvar j = 0; j < NUM_LEAVES; j++) begin : g_leaf
    assign node_s[NUM_LEAVES-1+j] = leaves_i[j];
    assign node_c[NUM_LEAVES-1+j] = '0;
  end

  for (genvar n = 0; n < NUM_LEAVES - 1; n++) begin : g_node
    prod_t a, b, c, d;
    prod_t s1, c1;

    assign a = node_s[2*n+1];
    assign b = node_c[2*n+1];
    assign c = node_s[2*n+2];
    assign d = node_c[2*n+2];

    // first 3:2 stage, carry moves up one bit
    assign s1 = a ^ b ^ c;
    assign c1 = ((a & b) | (a & c) | (b & c)) << 1;

    // second 3:2 stage folds in the fourth vector
    assign node_s[n] = s1 ^ c1 ^ d;
    assign node_c[n] = ((s1 & c1) | (s1 & d) | (c1 & d)) << 1;
  end

  assign sum_o   = node_s[0];
  assign carry_o = node_c[0];

endmodule

/* design/booth_radix4_multiplier.sv */
// ----------------------------------------------------------------------------
// booth_radix4_multiplier
// Signed radix-4 modified Booth multiplier with a full double-width product.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries multiplicand_i and
//   multiplier_i; a transaction happens on a clock edge with valid high and
//   stall low. Only the low OPERAND_BITS bits of each operand are used, read
//   as two's complement. Output channel out_valid_o / out_stall_i carries
//   product_o, the signed product sign-extended to 64 bits.
//   Datapath: the operands land in an input register, the Booth recoder, the
//   carry-save tree and the final adder are combinational, and the product is
//   held in an output register.
//   Throughput: one transaction per cycle in both directions while out_stall_i
//   is low; the input register and the output register each hold one item.
//   Stall: while out_stall_i holds a valid product, the product stays put and
//   the input register keeps filling; in_stall_o rises only when both
//   registers are full and the output is stalled.
//   Reset: rst_ni clears both valid flags; no product is offered after reset.
// ----------------------------------------------------------------------------
module booth_radix4_multiplier
  import brm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  multiplicand_i,
  input  logic signed [IN_W-1:0]  multiplier_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] product_o
);

  logic                    in_valid_q;
  logic [OPERAND_BITS-1:0] mcand_q, mplier_q;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] product_q, product_d;

  logic      in_ready, out_ready;
  pp_array_t pp;
  prod_t     tree_sum, tree_carry, sum_w;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  brm_booth_encoder u_encoder (
    .mcand_i  (mcand_q),
    .mplier_i (mplier_q),
    .pp_o     (pp)
  );

  brm_csa_tree u_tree (
    .leaves_i (pp),
    .sum_o    (tree_sum),
    .carry_o  (tree_carry)
  );

  // final carry-propagate add, then sign extend from the product msb
  assign sum_w     = tree_sum + tree_carry;
  assign product_d = OUT_W'(signed'(sum_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      mcand_q  <= multiplicand_i[OPERAND_BITS-1:0];
      mplier_q <= multiplier_i[OPERAND_BITS-1:0];
    end
    if (out_ready && in_valid_q) begin
      product_q <= product_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;

endmodule

/* design/brm_checker.sv */
// ----------------------------------------------------------------------------
// brm_checker
// Port-level checks on the multiplier: output handshake, stall cause and the
// product value after an input transaction whose output path is free.
// ----------------------------------------------------------------------------
`include "booth_radix4_multiplier_defines.svh"

module brm_checker
  import brm_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [IN_W-1:0]  multiplicand_i,
  input logic signed [IN_W-1:0]  multiplier_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] product_o
);

  `BRM_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  `BRM_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i, $stable(product_o))

  // input only backs up when the output is full and stalled
  `BRM_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // free output path: product shows once the operands pass the input and output registers
  `BRM_ASSERT_NEXT(a_product_value,
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i),
    out_valid_o && (product_o ==
      OUT_W'(signed'(OPERAND_BITS'($past(multiplicand_i, 2)))) *
      OUT_W'(signed'(OPERAND_BITS'($past(multiplier_i, 2))))))

endmodule

bind booth_radix4_multiplier brm_checker u_brm_checker (.*);
